/* src/rti_pkg.sv */
package rti_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_INDEX_W     = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_DIR_X   = 3'd3,
        CFG_DIR_Y   = 3'd4,
        CFG_DIR_Z   = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic valid;
        logic plane;
    } t_ctl;

endpackage

/* src/rti_plane.sv */
module rti_plane import rti_pkg::*; #(
    parameter int W  = COORD_WIDTH_DEF,
    parameter int F  = FRAC_BITS_DEF,
    parameter int RW = 3 * COORD_WIDTH_DEF + FRAC_BITS_DEF + 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [11:0][W-1:0]    i_tri,
    input  logic [2:0][W-1:0]     i_start,
    input  logic [2:0][W-1:0]     i_dir,
    output t_ctl                  o_ctl,
    output logic [11:0][W-1:0]    o_tri,
    output logic [RW-1:0]         o_num,
    output logic [RW-1:0]         o_den
);

    localparam logic signed [2*W+2:0] NEG_EPS1 = -((2*W+3)'(1) << F);

    logic                    r_v1, r_v2;
    t_ctl                    r_ctl3;
    logic [11:0][W-1:0]      r_tri1, r_tri2, r_tri3;
    logic signed [2*W-1:0]   r_pd [3];
    logic signed [2*W:0]     r_ps [3];
    logic signed [2*W+1:0]   r_d1;
    logic signed [2*W+2:0]   r_dist;
    logic [RW-1:0]           r_num, r_den;

    logic signed [2*W-1:0]   n_pd [3];
    logic signed [2*W:0]     n_ps [3];
    logic signed [2*W+1:0]   n_d1;
    logic signed [2*W+2:0]   n_dist;
    logic signed [2*W+2:0]   w_d1x;
    logic                    n_plane;

    always_comb begin
        logic signed [W:0] sa;
        logic signed [W-1:0] nv;
        for (int k = 0; k < 3; k++) begin
            nv       = $signed(i_tri[9+k]);
            sa       = (W+1)'($signed(i_start[k])) - (W+1)'($signed(i_tri[k]));
            n_pd[k]  = nv * $signed(i_dir[k]);
            n_ps[k]  = nv * sa;
        end
    end

    assign n_d1   = (2*W+2)'(r_pd[0]) + (2*W+2)'(r_pd[1]) + (2*W+2)'(r_pd[2]);
    assign n_dist = (2*W+3)'(r_ps[0]) + (2*W+3)'(r_ps[1]) + (2*W+3)'(r_ps[2]);
    assign w_d1x  = (2*W+3)'(r_d1);
    assign n_plane = (w_d1x < NEG_EPS1) && !r_dist[2*W+2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_v1         <= i_valid;
            r_v2         <= r_v1;
            r_ctl3.valid <= r_v2;
            r_ctl3.plane <= n_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tri1 <= i_tri;
            r_pd   <= n_pd;
            r_ps   <= n_ps;
            r_tri2 <= r_tri1;
            r_d1   <= n_d1;
            r_dist <= n_dist;
            r_tri3 <= r_tri2;
            r_num  <= RW'(r_dist) << F;
            r_den  <= RW'(-w_d1x);
        end
    end

    assign o_ctl = r_ctl3;
    assign o_tri = r_tri3;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

/* src/rti_div_step.sv */
module rti_div_step import rti_pkg::*; #(
    parameter int W   = COORD_WIDTH_DEF,
    parameter int RW  = 3 * COORD_WIDTH_DEF + FRAC_BITS_DEF + 4,
    parameter int BIT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic [11:0][W-1:0]    i_tri,
    input  logic [RW-1:0]         i_rem,
    input  logic [RW-1:0]         i_den,
    input  logic [W-1:0]          i_quo,
    output t_ctl                  o_ctl,
    output logic [11:0][W-1:0]    o_tri,
    output logic [RW-1:0]         o_rem,
    output logic [RW-1:0]         o_den,
    output logic [W-1:0]          o_quo
);

    t_ctl                r_ctl;
    logic [11:0][W-1:0]  r_tri;
    logic [RW-1:0]       r_rem, r_den;
    logic [W-1:0]        r_quo;
    logic [RW-1:0]       w_cand;
    logic                w_ge;

    assign w_cand = i_den << BIT;
    assign w_ge   = i_rem >= w_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tri <= i_tri;
            r_den <= i_den;
            r_rem <= w_ge ? (i_rem - w_cand) : i_rem;
            r_quo <= i_quo | (W'(w_ge) << BIT);
        end
    end

    assign o_ctl = r_ctl;
    assign o_tri = r_tri;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

/* src/rti_edge.sv */
module rti_edge import rti_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic [11:0][W-1:0]    i_tri,
    input  logic [W-1:0]          i_quo,
    input  logic [2:0][W-1:0]     i_start,
    input  logic [2:0][W-1:0]     i_dir,
    output logic                  o_valid,
    output logic                  o_plane_hit,
    output logic                  o_hit,
    output logic [W-2:0]          o_distance,
    output logic [2:0][W-1:0]     o_point
);

    localparam int L = W + 2;
    localparam logic signed [2*W:0] QMAX = {{(W+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W:0] QMIN = {{(W+2){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [3*W+4:0] NEG_EPS2 = -((3*W+5)'(1) << (2*F));

    t_ctl                    r_ctl [1:7];
    logic [11:0][W-1:0]      r_tri [1:5];
    logic [W-2:0]            r_t [1:7];
    logic [2:0][W-1:0]       r_q [2:7];
    logic signed [2*W-1:0]   r_td [3];
    logic signed [W:0]       r_rel [3][3];
    logic signed [W:0]       r_edg [3][3];
    logic signed [2*W+1:0]   r_cp [3][6];
    logic signed [2*W+2:0]   r_m [3][3];
    logic signed [2*W+2:0]   r_lo [3][3];
    logic signed [2*W:0]     r_hi [3][3];
    logic signed [3*W+2:0]   r_pr [3][3];

    logic                    r_valid, r_plane_hit, r_hit;
    logic [W-2:0]            r_distance;
    logic [2:0][W-1:0]       r_point;

    logic [W-2:0]            n_t;
    logic signed [2*W-1:0]   n_td [3];
    logic [2:0][W-1:0]       n_q;
    logic signed [W:0]       n_rel [3][3];
    logic signed [W:0]       n_edg [3][3];
    logic signed [2*W+1:0]   n_cp [3][6];
    logic signed [2*W+2:0]   n_m [3][3];
    logic signed [2*W+2:0]   n_lo [3][3];
    logic signed [2*W:0]     n_hi [3][3];
    logic signed [3*W+2:0]   n_pr [3][3];
    logic                    n_inside;

    assign n_t = i_quo[W-1] ? {(W-1){1'b1}} : i_quo[W-2:0];

    always_comb begin
        logic signed [2*W:0] s;
        int e1;
        for (int k = 0; k < 3; k++) begin
            n_td[k] = $signed({1'b0, n_t}) * $signed(i_dir[k]);
            s = (2*W+1)'($signed(i_start[k])) + (2*W+1)'(r_td[k] >>> F);
            n_q[k] = (s > QMAX) ? QMAX[W-1:0] : ((s < QMIN) ? QMIN[W-1:0] : s[W-1:0]);
        end
        for (int e = 0; e < 3; e++) begin
            e1 = (e == 2) ? 0 : e + 1;
            for (int k = 0; k < 3; k++) begin
                n_rel[e][k] = (W+1)'($signed(r_tri[2][e*3+k])) - (W+1)'($signed(r_q[2][k]));
                n_edg[e][k] = (W+1)'($signed(r_tri[2][e1*3+k]))
                            - (W+1)'($signed(r_tri[2][e*3+k]));
            end
            n_cp[e][0] = r_rel[e][1] * r_edg[e][2];
            n_cp[e][1] = r_rel[e][2] * r_edg[e][1];
            n_cp[e][2] = r_rel[e][2] * r_edg[e][0];
            n_cp[e][3] = r_rel[e][0] * r_edg[e][2];
            n_cp[e][4] = r_rel[e][0] * r_edg[e][1];
            n_cp[e][5] = r_rel[e][1] * r_edg[e][0];
            for (int k = 0; k < 3; k++) begin
                n_m[e][k]  = (2*W+3)'(r_cp[e][2*k]) - (2*W+3)'(r_cp[e][2*k+1]);
                n_lo[e][k] = $signed({1'b0, r_m[e][k][L-1:0]}) * $signed(r_tri[5][9+k]);
                n_hi[e][k] = $signed(r_m[e][k][2*W+2:L]) * $signed(r_tri[5][9+k]);
                n_pr[e][k] = ((3*W+3)'(r_hi[e][k]) <<< L) + (3*W+3)'(r_lo[e][k]);
            end
        end
    end

    always_comb begin
        logic signed [3*W+4:0] dot;
        n_inside = 1'b1;
        for (int e = 0; e < 3; e++) begin
            dot = (3*W+5)'(r_pr[e][0]) + (3*W+5)'(r_pr[e][1]) + (3*W+5)'(r_pr[e][2]);
            if (dot < NEG_EPS2) begin
                n_inside = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j <= 7; j++) begin
                r_ctl[j] <= '0;
            end
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_ctl[1] <= i_ctl;
            for (int j = 2; j <= 7; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
            r_valid <= r_ctl[7].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tri[1] <= i_tri;
            r_t[1]   <= n_t;
            r_td     <= n_td;
            for (int j = 2; j <= 5; j++) begin
                r_tri[j] <= r_tri[j-1];
            end
            for (int j = 2; j <= 7; j++) begin
                r_t[j] <= r_t[j-1];
            end
            r_q[2] <= n_q;
            for (int j = 3; j <= 7; j++) begin
                r_q[j] <= r_q[j-1];
            end
            r_rel <= n_rel;
            r_edg <= n_edg;
            r_cp  <= n_cp;
            r_m   <= n_m;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_pr  <= n_pr;
            r_plane_hit <= r_ctl[7].plane;
            r_hit       <= r_ctl[7].plane && n_inside;
            r_distance  <= r_ctl[7].plane ? r_t[7] : '0;
            r_point     <= (r_ctl[7].plane && n_inside) ? r_q[7] : '0;
        end
    end

    assign o_valid     = r_valid;
    assign o_plane_hit = r_plane_hit;
    assign o_hit       = r_hit;
    assign o_distance  = r_distance;
    assign o_point     = r_point;

endmodule

/* src/ray_triangle_intersect_core.sv */
// Streams triangles against one ray held in six configuration registers and returns one
// result transfer per triangle, in order: plane_hit, hit, the distance t and the hit point.
// One triangle is taken every cycle unless the output buffer is full; most of the pipeline is
// the divider, which resolves one quotient bit per pipeline stage. A two-entry output
// buffer keeps the input side moving while a result waits. Ray registers should be
// written only while no triangle is in flight.
module ray_triangle_intersect_core import rti_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]            i_cfg_index,
    input  logic [COORD_WIDTH-1:0]            i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
    // vertex_c_x, vertex_c_y, vertex_c_z, normal_x, normal_y, normal_z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // distance, hit_x, hit_y, hit_z
    output logic [((4*COORD_WIDTH+6)/8)*8-1:0]  m_axis_tdata,
    // plane_hit, hit
    output logic [1:0]                        m_axis_tuser
);

    localparam int W      = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int RW     = 3 * W + F + 4;
    localparam int OUT_DW = ((4 * W + 6) / 8) * 8;
    localparam int RES_W  = 4 * W + 1;

    logic [2:0][W-1:0]       r_start, r_dir;
    logic                    r_out_valid, r_skid_valid;
    logic [RES_W-1:0]        r_out, r_skid;

    logic                    w_en;
    t_ctl                    w_ctl [0:W];
    logic [11:0][W-1:0]      w_tri [0:W];
    logic [RW-1:0]           w_rem [0:W];
    logic [RW-1:0]           w_den [0:W];
    logic [W-1:0]            w_quo [0:W];
    logic                    w_res_valid, w_plane_hit, w_hit;
    logic [W-2:0]            w_distance;
    logic [2:0][W-1:0]       w_point;
    logic [RES_W-1:0]        w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_dir   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_START_X: r_start[0] <= i_cfg_data;
                CFG_START_Y: r_start[1] <= i_cfg_data;
                CFG_START_Z: r_start[2] <= i_cfg_data;
                CFG_DIR_X:   r_dir[0]   <= i_cfg_data;
                CFG_DIR_Y:   r_dir[1]   <= i_cfg_data;
                CFG_DIR_Z:   r_dir[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    rti_plane #(.W(W), .F(F), .RW(RW)) u_plane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_tri   (s_axis_tdata[12*W-1:0]),
        .i_start (r_start),
        .i_dir   (r_dir),
        .o_ctl   (w_ctl[0]),
        .o_tri   (w_tri[0]),
        .o_num   (w_rem[0]),
        .o_den   (w_den[0])
    );

    assign w_quo[0] = '0;

    for (genvar j = 0; j < W; j++) begin : g_div
        rti_div_step #(.W(W), .RW(RW), .BIT(W - 1 - j)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[j]),
            .i_tri   (w_tri[j]),
            .i_rem   (w_rem[j]),
            .i_den   (w_den[j]),
            .i_quo   (w_quo[j]),
            .o_ctl   (w_ctl[j+1]),
            .o_tri   (w_tri[j+1]),
            .o_rem   (w_rem[j+1]),
            .o_den   (w_den[j+1]),
            .o_quo   (w_quo[j+1])
        );
    end

    rti_edge #(.W(W), .F(F)) u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (w_ctl[W]),
        .i_tri       (w_tri[W]),
        .i_quo       (w_quo[W]),
        .i_start     (r_start),
        .i_dir       (r_dir),
        .o_valid     (w_res_valid),
        .o_plane_hit (w_plane_hit),
        .o_hit       (w_hit),
        .o_distance  (w_distance),
        .o_point     (w_point)
    );

    assign w_res = {w_point[2], w_point[1], w_point[0], w_distance, w_hit, w_plane_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_res;
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out[1:0];
    assign m_axis_tdata  = {{(OUT_DW-(RES_W-2)){1'b0}}, r_out[RES_W-1:2]};

endmodule

/* tb/sv/tb_ray_triangle_intersect_core.sv */
module tb_ray_triangle_intersect_core;
    import rti_pkg::*;

    localparam int CW       = COORD_WIDTH_DEF;
    localparam int FB       = FRAC_BITS_DEF;
    localparam int IDLE_MAX = 4000;
    localparam int SETTLE   = CW + 30;

    typedef logic signed [255:0] wint_t;
    typedef logic [11:0][CW-1:0] tri_t;
    typedef logic [5:0][CW-1:0] ray_t;

    typedef struct packed {
        logic          plane;
        logic          hit;
        logic [CW-2:0] distance;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] pz;
    } hit_t;

    localparam wint_t EPS1 = 64'sd65536;
    localparam wint_t EPS2 = 64'sd4294967296;
    localparam wint_t PMAX = 64'sd2147483647;
    localparam wint_t PMIN = -64'sd2147483648;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [CW-1:0]             i_cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // vertex_a_x..z, vertex_b_x..z, vertex_c_x..z, normal_x..z
    logic [12*CW-1:0]          s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // distance, hit_x, hit_y, hit_z
    logic [127:0]              m_axis_tdata;
    // plane_hit, hit
    logic [1:0]                m_axis_tuser;

    ray_triangle_intersect_core dut (.*);

    always #4 i_clk = ~i_clk;

    logic signed [CW-1:0] ray_reg [6] = '{default: '0};
    hit_t  hit_q [$];
    int    err_cnt = 0;
    int    idle_cnt = 0;
    bit    tx_on = 0;
    int    tx_burst = 0;
    logic  hold_rx = 1'b0;
    logic [15:0] rx_cyc = '0;

    function automatic hit_t predict_hit(tri_t tr);
        wint_t s[3], d[3], n[3], q[3], rel[3], edg[3], m[3];
        wint_t v[3][3];
        wint_t d1, plane_dist, num, den, t;
        hit_t  r;
        bit    in_tri;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            s[k] = ray_reg[CFG_START_X + k];
            d[k] = ray_reg[CFG_DIR_X + k];
            n[k] = $signed(tr[9 + k]);
            for (int e = 0; e < 3; e++) v[e][k] = $signed(tr[e * 3 + k]);
        end
        d1 = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
        plane_dist = (n[0] * s[0] + n[1] * s[1] + n[2] * s[2])
                   - (n[0] * v[0][0] + n[1] * v[0][1] + n[2] * v[0][2]);
        if (d1 < -EPS1 && plane_dist >= 0) begin
            r.plane = 1'b1;
            den = -d1;
            num = plane_dist <<< FB;
            if (num >= (den <<< (CW - 1))) t = PMAX;
            else t = num / den;
            r.distance = t[CW-2:0];
            for (int k = 0; k < 3; k++) begin
                q[k] = s[k] + ((t * d[k]) >>> FB);
                if (q[k] > PMAX) q[k] = PMAX;
                if (q[k] < PMIN) q[k] = PMIN;
            end
            in_tri = 1;
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    rel[k] = v[e][k] - q[k];
                    edg[k] = v[(e + 1) % 3][k] - v[e][k];
                end
                m[0] = rel[1] * edg[2] - rel[2] * edg[1];
                m[1] = rel[2] * edg[0] - rel[0] * edg[2];
                m[2] = rel[0] * edg[1] - rel[1] * edg[0];
                if (m[0] * n[0] + m[1] * n[1] + m[2] * n[2] < -EPS2) in_tri = 0;
            end
            if (in_tri) begin
                r.hit = 1'b1;
                r.px = q[0][CW-1:0];
                r.py = q[1][CW-1:0];
                r.pz = q[2][CW-1:0];
            end
        end
        return r;
    endfunction

    // Triangle placed around a point on the current ray line, facing the ray.
    function automatic tri_t aimed_tri();
        longint s, d, p[3], v[3][3], e1[3], e2[3], n[3], tt, dn, tmp;
        tri_t tr;
        tt = longint'($urandom_range(0, 327680)) - 65536;
        for (int k = 0; k < 3; k++) begin
            s = longint'(ray_reg[CFG_START_X + k]);
            d = longint'(ray_reg[CFG_DIR_X + k]);
            p[k] = s + ((d * tt) >>> FB);
            for (int e = 0; e < 3; e++)
                v[e][k] = p[k] + longint'($urandom_range(0, 524288)) - 262144;
        end
        for (int k = 0; k < 3; k++) begin
            e1[k] = v[1][k] - v[0][k];
            e2[k] = v[2][k] - v[0][k];
        end
        n[0] = (e1[1] * e2[2] - e1[2] * e2[1]) >>> FB;
        n[1] = (e1[2] * e2[0] - e1[0] * e2[2]) >>> FB;
        n[2] = (e1[0] * e2[1] - e1[1] * e2[0]) >>> FB;
        dn = 0;
        for (int k = 0; k < 3; k++) dn += n[k] * longint'(ray_reg[CFG_DIR_X + k]);
        if (dn > 0) begin
            for (int k = 0; k < 3; k++) begin
                n[k] = -n[k];
                tmp = v[1][k];
                v[1][k] = v[2][k];
                v[2][k] = tmp;
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int e = 0; e < 3; e++) tr[e * 3 + k] = v[e][k][CW-1:0];
            tr[9 + k] = n[k][CW-1:0];
        end
        return tr;
    endfunction

    function automatic tri_t noise_tri();
        tri_t tr;
        for (int i = 0; i < 12; i++) tr[i] = $urandom;
        return tr;
    endfunction

    function automatic tri_t make_tri(input int ax, ay, az, bx, by, bz,
                                      input int cx, cy, cz, nx, ny, nz);
        return {nz, ny, nx, cz, cy, cx, bz, by, bx, az, ay, ax};
    endfunction

    task automatic tx_stop();
        if (tx_on) begin
            s_axis_tvalid <= 1'b0;
            tx_on = 0;
        end
    endtask

    task automatic send_tri(input tri_t tr);
        s_axis_tdata <= tr;
        s_axis_tvalid <= 1'b1;
        tx_on = 1;
        do @(posedge i_clk); while (!s_axis_tready);
        hit_q.push_back(predict_hit(tr));
        if (tx_burst == 0) begin
            tx_stop();
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            tx_burst = $urandom_range(0, 40);
        end else begin
            tx_burst--;
        end
    endtask

    task automatic wait_results();
        tx_stop();
        while (hit_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_ray(input ray_t r, input bit spare);
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            if (i < 6 || spare) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= 3'(i);
                i_cfg_data <= (i < 6) ? r[i] : CW'($urandom);
                do @(posedge i_clk); while (!o_cfg_ready);
                if (i_cfg_index <= CFG_DIR_Z) ray_reg[i_cfg_index] = i_cfg_data;
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic ray_t aimed_ray();
        ray_t r;
        for (int k = 0; k < 3; k++) begin
            r[CFG_START_X + k] = CW'(int'($urandom_range(0, 8388608)) - 4194304);
            r[CFG_DIR_X + k] = CW'(int'($urandom_range(0, 524288)) - 262144);
        end
        return r;
    endfunction

    task automatic test_reset_ray();
        send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tri({12{32'h7fffffff}});
        send_tri({12{32'h80000000}});
        send_tri({12{32'hffffffff}});
    endtask

    task automatic test_directed();
        int one;
        one = 65536;
        set_ray({32'hffff0000, 32'h0, 32'h0, 32'(10 * one), 32'h0, 32'h0}, 1'b0);
        // inside, outside an edge, back face, plane behind start, zero normal
        send_tri(make_tri(-one, -one, 0, one, -one, 0, 0, one, 0, 0, 0, one));
        send_tri(make_tri(4 * one, -one, 0, 6 * one, -one, 0, 5 * one, one, 0, 0, 0, one));
        send_tri(make_tri(-one, -one, 0, 0, one, 0, one, -one, 0, 0, 0, -one));
        send_tri(make_tri(-one, -one, 20 * one, one, -one, 20 * one, 0, one, 20 * one,
                          0, 0, one));
        send_tri(make_tri(-one, -one, 0, one, -one, 0, 0, one, 0, 0, 0, 0));
        send_tri(make_tri(-one, -one, 10 * one, one, -one, 10 * one, 0, one, 10 * one,
                          0, 0, one));
        send_tri({12{32'h7fffffff}});
        send_tri({12{32'h80000000}});
        send_tri('0);
        // huge distance saturates; the point then clamps on x and y
        set_ray({32'hfffffffe, 32'h80000000, 32'h7fffffff, 32'h40000000, 32'h0, 32'h0},
                1'b1);
        send_tri(make_tri(-one, -one, 0, one, -one, 0, 0, one, 0, 0, 0, one));
        send_tri(make_tri(-one, -one, 0, one, -one, 0, 0, one, 0, 0, 0, 32'h7fffffff));
        send_tri(make_tri(0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0, one));
    endtask

    task automatic test_extreme_rays();
        set_ray({6{32'h7fffffff}}, 1'b1);
        repeat (20) send_tri(noise_tri());
        set_ray({{3{32'h80000000}}, {3{32'h7fffffff}}}, 1'b1);
        repeat (20) send_tri(noise_tri());
        set_ray({{3{32'h7fffffff}}, {3{32'h80000000}}}, 1'b0);
        repeat (20) send_tri(noise_tri());
    endtask

    task automatic test_random_rays();
        for (int ph = 0; ph < 13; ph++) begin
            set_ray(aimed_ray(), ph[0]);
            repeat (130) begin
                if ($urandom_range(0, 3) != 0) send_tri(aimed_tri());
                else send_tri(noise_tri());
            end
        end
    endtask

    task automatic test_backpressure();
        set_ray(aimed_ray(), 1'b0);
        fork
            begin
                hold_rx <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        tx_burst = 200;
        repeat (100) send_tri(aimed_tri());
        wait_results();
        repeat (40) send_tri(aimed_tri());
    endtask

    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1'b1;
        if (hold_rx) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_cyc[10:9])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_cyc[2:0] != 3'd0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        hit_t exp_r;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cnt <= 0;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
            if (idle_cnt >= IDLE_MAX) begin
                $display("status: fail");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (hit_q.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    err_cnt++;
                end else begin
                    exp_r = hit_q.pop_front();
                    if (m_axis_tuser[0] !== exp_r.plane) begin
                        $error("plane_hit exp %0d got %0d", exp_r.plane, m_axis_tuser[0]);
                        err_cnt++;
                    end
                    if (m_axis_tuser[1] !== exp_r.hit) begin
                        $error("hit exp %0d got %0d", exp_r.hit, m_axis_tuser[1]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[30:0] !== exp_r.distance) begin
                        $error("distance exp %h got %h", exp_r.distance, m_axis_tdata[30:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[62:31] !== exp_r.px) begin
                        $error("hit_x exp %h got %h", exp_r.px, m_axis_tdata[62:31]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[94:63] !== exp_r.py) begin
                        $error("hit_y exp %h got %h", exp_r.py, m_axis_tdata[94:63]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[126:95] !== exp_r.pz) begin
                        $error("hit_z exp %h got %h", exp_r.pz, m_axis_tdata[126:95]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_ray();
        test_directed();
        test_extreme_rays();
        test_random_rays();
        test_backpressure();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/rti_pkg.sv
src/rti_plane.sv
src/rti_div_step.sv
src/rti_edge.sv
src/ray_triangle_intersect_core.sv
tb/sv/tb_ray_triangle_intersect_core.sv
